// File: hdl/playfair_pkg.sv
package playfair_pkg;

  // Letter codes, A=0 through Z=25.
  typedef logic [4:0] letter_t;

  localparam letter_t CODE_I = 5'd8;
  localparam letter_t CODE_J = 5'd9;
  localparam letter_t CODE_X = 5'd23;

  // Key square held as [row][column].
  localparam int SIDE = 5;
  typedef letter_t [SIDE-1:0][SIDE-1:0] square_t;
  typedef logic [2:0] coord_t;

  // Configuration register indexes and port widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 60;
  localparam int CELLS_PER_WORD = 12;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CELLS_LOW = 2'd0,
    REG_CELLS_MID = 2'd1,
    REG_CELL_LAST = 2'd2
  } cfg_reg_t;

  // Encrypted digram handed from the core to the result buffer.
  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    not_found;
  } digram_res_t;

  // One result entry as it leaves the block.
  typedef struct packed {
    letter_t cipher_letter;
    logic    end_of_message_res;
    logic    not_found;
  } result_t;

endpackage

// File: hdl/playfair_if.sv
// Plaintext letter channel.
interface playfair_in_if
  import playfair_pkg::*;
  ();
  logic    valid;
  logic    ready;
  letter_t letter;
  logic    end_of_message;

  modport source (output valid, output letter, output end_of_message, input ready);
  modport sink (input valid, input letter, input end_of_message, output ready);
endinterface

// Ciphertext letter channel.
interface playfair_out_if
  import playfair_pkg::*;
  ();
  logic    valid;
  logic    ready;
  letter_t cipher_letter;
  logic    end_of_message_res;
  logic    not_found;

  modport source (output valid, output cipher_letter, output end_of_message_res,
                  output not_found, input ready);
  modport sink (input valid, input cipher_letter, input end_of_message_res,
                input not_found, output ready);
endinterface

// File: hdl/playfair_digram_encrypt_top.sv
// Channel   Direction  Payload                                           Accepted when
// plain     in         letter[4:0], end_of_message                       valid && ready
// cipher    out        cipher_letter[4:0], end_of_message_res, not_found valid && ready
// cfg       in         cfg_index[1:0], cfg_data[59:0]                    cfg_we
//
// A letter is taken every cycle unless the output stalls; a completed digram is
// encrypted combinationally between the digram register and the result buffer.
// Results leave at one per cycle, so the output port sets the sustained rate: one
// letter per cycle on average, since a digram of two letters gives two results.
// Reset (rst, synchronous) clears the key square, the held half and all valid state.
// A stalled output holds the digram register, and then the input, back.
module playfair_digram_encrypt_top
  import playfair_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  playfair_in_if.sink            plain,
  playfair_out_if.source         cipher
);

  // Key square registers.
  logic [CFG_DATA_W-1:0] cells_low;
  logic [CFG_DATA_W-1:0] cells_mid;
  letter_t               cell_last;
  square_t               square;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_low <= '0;
      cells_mid <= '0;
      cell_last <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELLS_LOW: cells_low <= cfg_data;
        REG_CELLS_MID: cells_mid <= cfg_data;
        REG_CELL_LAST: cell_last <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Spread the register words into rows and columns.
  always_comb begin
    for (int k = 0; k < CELLS_PER_WORD; k++) begin
      square[k / SIDE][k % SIDE] = cells_low[5*k +: 5];
      square[(k + CELLS_PER_WORD) / SIDE][(k + CELLS_PER_WORD) % SIDE] =
        cells_mid[5*k +: 5];
    end
    square[SIDE-1][SIDE-1] = cell_last;
  end

  // Handshake qualifiers.
  logic   in_acc, out_acc;
  logic   dig_valid, dig_go, buf_free;
  logic [1:0] res_cnt;

  assign out_acc  = cipher.valid && cipher.ready;
  assign buf_free = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_acc);
  assign dig_go   = dig_valid && buf_free;
  assign plain.ready = !dig_valid || dig_go;
  assign in_acc   = plain.valid && plain.ready;

  // Pairing of letters into digrams.
  logic    pending;
  letter_t held;
  logic    pair_done;
  letter_t dig_first, dig_second;
  logic    dig_eom;

  assign pair_done = in_acc && (pending || plain.end_of_message);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      held      <= '0;
      dig_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!pending && !plain.end_of_message) begin
          pending <= 1'b1;
          held    <= plain.letter;
        end else begin
          pending <= 1'b0;
          held    <= '0;
        end
      end
      if (pair_done) begin
        dig_valid <= 1'b1;
      end else if (dig_go) begin
        dig_valid <= 1'b0;
      end
    end
  end

  // Digram payload register.
  always_ff @(posedge clk) begin
    if (pair_done) begin
      dig_first  <= pending ? held : plain.letter;
      dig_second <= pending ? plain.letter : CODE_X;
      dig_eom    <= plain.end_of_message;
    end
  end

  // Square lookup and Playfair rules.
  digram_res_t core_res;

  playfair_core u_core (
    .square (square),
    .first  (dig_first),
    .second (dig_second),
    .res    (core_res)
  );

  // Two-entry result buffer; head is presented on the output channel.
  result_t head, tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (dig_go) begin
      res_cnt <= core_res.not_found ? 2'd1 : 2'd2;
    end else if (out_acc) begin
      res_cnt <= res_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_go) begin
      if (core_res.not_found) begin
        head <= '{cipher_letter: '0, end_of_message_res: dig_eom, not_found: 1'b1};
      end else begin
        head <= '{cipher_letter: core_res.first, end_of_message_res: 1'b0,
                  not_found: 1'b0};
      end
      tail <= '{cipher_letter: core_res.second, end_of_message_res: dig_eom,
                not_found: 1'b0};
    end else if (out_acc) begin
      head <= tail;
    end
  end

  assign cipher.valid              = (res_cnt != 2'd0);
  assign cipher.cipher_letter      = head.cipher_letter;
  assign cipher.end_of_message_res = head.end_of_message_res;
  assign cipher.not_found          = head.not_found;

`ifndef NO_ASSERTIONS
  // A missing letter yields exactly one flagged result with a zero letter.
  a_not_found_single: assert property (@(posedge clk) disable iff (rst)
    dig_go && core_res.not_found |=> res_cnt == 2'd1 && cipher.not_found &&
    cipher.cipher_letter == '0)
    else $error("missing letter did not give a single flagged result");

  // A full buffer that is not drained keeps both results.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    res_cnt == 2'd2 && !out_acc |=> res_cnt == 2'd2 && $stable(head))
    else $error("result buffer lost an entry while stalled");

  // A lone first letter is held and produces no digram.
  a_first_held: assert property (@(posedge clk) disable iff (rst)
    in_acc && !pending && !plain.end_of_message |=> pending &&
    held == $past(plain.letter))
    else $error("first letter of a digram was not held");

  // The buffer never claims more than two results.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    res_cnt != 2'd3)
    else $error("result count out of range");
`endif

endmodule

// File: hdl/playfair_core.sv
module playfair_core
  import playfair_pkg::*;
(
  input  square_t     square,
  input  letter_t     first,
  input  letter_t     second,
  output digram_res_t res
);

  typedef struct packed {
    logic   found;
    coord_t row;
    coord_t col;
  } pos_t;

  // Scan the square in reverse so the first match in row-major order wins.
  function automatic pos_t locate(square_t sq, letter_t l);
    pos_t    p;
    letter_t key;
    p   = '0;
    key = (l == CODE_J) ? CODE_I : l;
    for (int r = SIDE - 1; r >= 0; r--) begin
      for (int c = SIDE - 1; c >= 0; c--) begin
        if (sq[r][c] == key) begin
          p.found = 1'b1;
          p.row   = coord_t'(r);
          p.col   = coord_t'(c);
        end
      end
    end
    return p;
  endfunction

  // Step one place with wraparound inside the square.
  function automatic coord_t wrap_inc(coord_t v);
    return (v == coord_t'(SIDE - 1)) ? '0 : v + coord_t'(1);
  endfunction

  pos_t   p1, p2;
  coord_t r1, c1, r2, c2;

  always_comb begin
    p1 = locate(square, first);
    p2 = locate(square, second);
    r1 = p1.row;
    c1 = p1.col;
    r2 = p2.row;
    c2 = p2.col;
    if (p1.row == p2.row) begin
      // Same row: both move one column right.
      c1 = wrap_inc(p1.col);
      c2 = wrap_inc(p2.col);
    end else if (p1.col == p2.col) begin
      // Same column: both move one row down.
      r1 = wrap_inc(p1.row);
      r2 = wrap_inc(p2.row);
    end else begin
      // Rectangle: swap the columns.
      c1 = p2.col;
      c2 = p1.col;
    end
    res.not_found = !(p1.found && p2.found);
    res.first     = square[r1][c1];
    res.second    = square[r2][c2];
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import playfair_pkg::*;

  // Index past the end of the register map; writes to it must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    letter_t letter;
    logic    eom;
  } plain_item_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  playfair_in_if  plain ();
  playfair_out_if cipher ();

  playfair_digram_encrypt_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plain     (plain),
    .cipher    (cipher)
  );

  // Letters waiting to be sent and cipher letters still owed by the block.
  plain_item_t plain_q[$];
  result_t     cipher_due_q[$];
  int          mismatches = 0;
  bit          steady = 1'b0;

  // Key square as the stimulus generator knows it, row-major.
  letter_t gen_sq[25];

  // Shadow of the key square registers and of the open digram.
  logic [CFG_DATA_W-1:0] sq_low;
  logic [CFG_DATA_W-1:0] sq_mid;
  letter_t               sq_last;
  letter_t               held_ltr;
  logic                  half_held;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < 40) begin
      $display("%0t mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic letter_t key_cell(input int unsigned pos);
    if (pos < CELLS_PER_WORD) return sq_low[5*pos +: 5];
    if (pos < 2*CELLS_PER_WORD) return sq_mid[5*(pos-CELLS_PER_WORD) +: 5];
    return sq_last;
  endfunction

  // First matching position in row-major order, or 25 when absent.
  function automatic int unsigned find_pos(input letter_t l);
    letter_t key;
    key = (l == CODE_J) ? CODE_I : l;
    for (int unsigned p = 0; p < SIDE*SIDE; p++) begin
      if (key_cell(p) == key) return p;
    end
    return SIDE*SIDE;
  endfunction

  // Pair up the letter with the held half and queue the cipher letters it produces.
  task automatic encrypt_letter(input letter_t l, input logic eom);
    letter_t     a, b;
    int unsigned p1, p2, r1, c1, r2, c2, t;
    result_t     res;
    if (!half_held) begin
      if (!eom) begin
        held_ltr  = l;
        half_held = 1'b1;
        return;
      end
      a = l;
      b = CODE_X;
    end else begin
      a = held_ltr;
      b = l;
    end
    half_held = 1'b0;
    held_ltr  = '0;

    p1 = find_pos(a);
    p2 = find_pos(b);
    if (p1 >= SIDE*SIDE || p2 >= SIDE*SIDE) begin
      res.cipher_letter      = '0;
      res.end_of_message_res = eom;
      res.not_found          = 1'b1;
      cipher_due_q.push_back(res);
      return;
    end

    r1 = p1 / SIDE;
    c1 = p1 % SIDE;
    r2 = p2 / SIDE;
    c2 = p2 % SIDE;
    if (r1 == r2) begin
      c1 = (c1 + 1) % SIDE;
      c2 = (c2 + 1) % SIDE;
    end else if (c1 == c2) begin
      r1 = (r1 + 1) % SIDE;
      r2 = (r2 + 1) % SIDE;
    end else begin
      t  = c1;
      c1 = c2;
      c2 = t;
    end

    res.cipher_letter      = key_cell(r1*SIDE + c1);
    res.end_of_message_res = 1'b0;
    res.not_found          = 1'b0;
    cipher_due_q.push_back(res);
    res.cipher_letter      = key_cell(r2*SIDE + c2);
    res.end_of_message_res = eom;
    cipher_due_q.push_back(res);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive
    plain_item_t nxt;
    if (rst) begin
      plain.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!plain.valid || plain.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        plain.valid <= 1'b0;
      end else if (plain_q.size() != 0) begin
        nxt = plain_q.pop_front();
        plain.valid <= 1'b1;
        plain.letter <= nxt.letter;
        plain.end_of_message <= nxt.eom;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        plain.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on a rotating 32-bit pattern that is reloaded after a full rotation.
  logic [31:0] stall_pat;
  int          stall_age = 0;

  always @(posedge clk) begin : backpressure
    if (rst) begin
      cipher.ready <= 1'b0;
      stall_age = 0;
    end else begin
      if (stall_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = $urandom;
          2: stall_pat = $urandom | $urandom;
          default: stall_pat = $urandom & $urandom;
        endcase
        stall_age = 32;
      end
      stall_age--;
      cipher.ready <= steady | stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
    end
  end

  // Monitor: track register writes, predict on each input transaction and
  // check each output transaction against the oldest prediction.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      sq_low    = '0;
      sq_mid    = '0;
      sq_last   = '0;
      held_ltr  = '0;
      half_held = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CELLS_LOW: sq_low = cfg_data;
          REG_CELLS_MID: sq_mid = cfg_data;
          REG_CELL_LAST: sq_last = cfg_data[4:0];
          default: ;
        endcase
      end
      if (plain.valid && plain.ready) begin
        encrypt_letter(plain.letter, plain.end_of_message);
      end
      if (cipher.valid && cipher.ready) begin
        if (cipher_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result letter=%0d eom=%0b not_found=%0b",
                                  cipher.cipher_letter, cipher.end_of_message_res,
                                  cipher.not_found));
        end else begin
          want = cipher_due_q.pop_front();
          if (cipher.cipher_letter !== want.cipher_letter) begin
            flag_mismatch($sformatf("cipher_letter %0d, expected %0d",
                                    cipher.cipher_letter, want.cipher_letter));
          end
          if (cipher.end_of_message_res !== want.end_of_message_res) begin
            flag_mismatch($sformatf("end_of_message_res %0b, expected %0b",
                                    cipher.end_of_message_res, want.end_of_message_res));
          end
          if (cipher.not_found !== want.not_found) begin
            flag_mismatch($sformatf("not_found %0b, expected %0b",
                                    cipher.not_found, want.not_found));
          end
        end
      end
    end
  end

  function automatic letter_t code_of(input byte ch);
    return letter_t'(ch - "A");
  endfunction

  task automatic push_letter(input letter_t l, input logic eom);
    plain_item_t it;
    it.letter = l;
    it.eom    = eom;
    plain_q.push_back(it);
  endtask

  // Wait until every letter is sent and every cipher letter is back, then settle.
  task automatic drain_and_settle();
    do @(posedge clk);
    while (plain_q.size() != 0 || plain.valid || cipher_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the square held in gen_sq, with a stray write to the unused index first.
  task automatic load_square();
    logic [CFG_DATA_W-1:0] low, mid, junk;
    for (int k = 0; k < CELLS_PER_WORD; k++) begin
      low[5*k +: 5] = gen_sq[k];
      mid[5*k +: 5] = gen_sq[CELLS_PER_WORD + k];
    end
    junk = CFG_DATA_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= junk;
    @(posedge clk);
    cfg_index <= REG_CELLS_LOW;
    cfg_data <= low;
    @(posedge clk);
    cfg_index <= REG_CELLS_MID;
    cfg_data <= mid;
    @(posedge clk);
    cfg_index <= REG_CELL_LAST;
    cfg_data <= {junk[CFG_DATA_W-1:5], gen_sq[2*CELLS_PER_WORD]};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic alphabet_square();
    for (int k = 0; k < SIDE*SIDE; k++) begin
      gen_sq[k] = (k < CODE_J) ? letter_t'(k) : letter_t'(k + 1);
    end
  endtask

  // Square kinds: 0 shuffled alphabet, 1 shuffled with J in place of I,
  // 2 raw random codes, 3 all ones, 4 all zero, 5 shuffled with a few holes.
  task automatic make_square(input int kind);
    int      j;
    letter_t t;
    alphabet_square();
    for (int k = SIDE*SIDE - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = gen_sq[k];
      gen_sq[k] = gen_sq[j];
      gen_sq[j] = t;
    end
    for (int k = 0; k < SIDE*SIDE; k++) begin
      case (kind)
        1: if (gen_sq[k] == CODE_I) gen_sq[k] = CODE_J;
        2: gen_sq[k] = letter_t'($urandom_range(0, 31));
        3: gen_sq[k] = '1;
        4: gen_sq[k] = '0;
        default: ;
      endcase
    end
    if (kind == 5) begin
      repeat (3) gen_sq[$urandom_range(0, SIDE*SIDE - 1)] = letter_t'($urandom_range(26, 31));
    end
  endtask

  // A letter taken from a square position, or a random one where the square holds none.
  function automatic letter_t pick_letter(input int unsigned pos);
    letter_t v;
    v = gen_sq[pos];
    if (v > 25) return letter_t'($urandom_range(0, 25));
    if (v == CODE_I && $urandom_range(0, 3) == 0) return CODE_J;
    return v;
  endfunction

  // One message of random length, built from digrams that favor shared rows,
  // shared columns and repeated letters as well as arbitrary pairs.
  task automatic queue_message(input int unsigned len);
    int unsigned pos, other;
    letter_t     l1, l2;
    for (int unsigned k = 0; k < len; k += 2) begin
      pos = $urandom_range(0, SIDE*SIDE - 1);
      case ($urandom_range(0, 4))
        0: other = (pos / SIDE) * SIDE + $urandom_range(0, SIDE - 1);
        1: other = $urandom_range(0, SIDE - 1) * SIDE + pos % SIDE;
        2: other = pos;
        default: other = SIDE*SIDE;
      endcase
      if (other == SIDE*SIDE) begin
        l1 = letter_t'($urandom_range(0, 25));
        l2 = letter_t'($urandom_range(0, 25));
      end else begin
        l1 = pick_letter(pos);
        l2 = pick_letter(other);
      end
      push_letter(l1, k + 1 == len);
      if (k + 1 < len) push_letter(l2, k + 2 == len);
    end
  endtask

  int square_kinds[9] = '{0, 5, 2, 0, 3, 1, 0, 4, 0};

  initial begin
    int unsigned sent;
    int unsigned len;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    plain.valid = 1'b0;
    plain.letter = '0;
    plain.end_of_message = 1'b0;
    cipher.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Square left by reset: every cell is A, so only A pairs encrypt.
    push_letter(code_of("A"), 1'b0);
    push_letter(code_of("A"), 1'b0);
    push_letter(code_of("B"), 1'b1);
    drain_and_settle();

    // Plain alphabet square: row, row wrap, column wrap, rectangle, repeated
    // letter, J read as I, end on the second letter, odd end padded with X.
    alphabet_square();
    load_square();
    push_letter(code_of("D"), 1'b0);
    push_letter(code_of("E"), 1'b0);
    push_letter(code_of("E"), 1'b0);
    push_letter(code_of("Z"), 1'b0);
    push_letter(code_of("A"), 1'b0);
    push_letter(code_of("G"), 1'b0);
    push_letter(code_of("C"), 1'b0);
    push_letter(code_of("C"), 1'b0);
    push_letter(code_of("J"), 1'b0);
    push_letter(code_of("K"), 1'b0);
    push_letter(code_of("Y"), 1'b0);
    push_letter(code_of("A"), 1'b1);
    push_letter(code_of("Z"), 1'b1);
    push_letter(code_of("A"), 1'b0);
    push_letter(code_of("Z"), 1'b1);
    drain_and_settle();

    // Holes in the square: Z and X missing, J stored where I belongs.
    gen_sq[24] = 5'd31;
    gen_sq[22] = 5'd26;
    gen_sq[8]  = CODE_J;
    load_square();
    push_letter(code_of("Z"), 1'b0);
    push_letter(code_of("A"), 1'b0);
    push_letter(code_of("A"), 1'b1);
    push_letter(code_of("M"), 1'b0);
    push_letter(code_of("N"), 1'b0);
    push_letter(code_of("B"), 1'b0);
    push_letter(code_of("I"), 1'b0);
    push_letter(code_of("Q"), 1'b0);
    push_letter(code_of("Y"), 1'b1);
    drain_and_settle();

    // Random messages over a run of different squares.
    foreach (square_kinds[ph]) begin
      make_square(square_kinds[ph]);
      load_square();
      steady = (ph == 3 || ph == 7);
      sent = 0;
      while (sent < 88) begin
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        queue_message(len);
        sent += len;
      end
      drain_and_settle();
    end

    if (mismatches == 0) begin
      $display("[playfair_digram_encrypt_top] OK");
    end else begin
      $display("[playfair_digram_encrypt_top] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("[playfair_digram_encrypt_top] ERROR");
    $finish;
  end

endmodule
